### sv/fla_pkg.sv
// Shared types and constants for the free-list slot allocator.
// No dependencies; every other file in this folder refers to it by scoped names.
package fla_pkg;

  // Pool size and the index widths that follow from it.
  localparam int SLOT_COUNT = 64;
  localparam int IDX_W      = $clog2(SLOT_COUNT);
  localparam int LINK_W     = $clog2(SLOT_COUNT + 1);

  // Requested action as it arrives on the input channel.
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // Classified command carried from the front end to the back end.
  typedef logic [1:0] op_t;
  localparam op_t OP_ALLOC = 2'd0;
  localparam op_t OP_FREE  = 2'd1;
  localparam op_t OP_NULL  = 2'd2;
  localparam int  OP_W     = 2;

  // Result status codes.
  typedef logic [1:0] status_t;
  localparam status_t STAT_ALLOCATED = 2'd0;
  localparam status_t STAT_EXHAUSTED = 2'd1;
  localparam status_t STAT_FREED     = 2'd2;
  localparam status_t STAT_NULL_FREE = 2'd3;

  // Fixed port widths of the payload fields.
  localparam int SLOT_PORT_W  = 6;
  localparam int COUNT_PORT_W = 7;
  localparam int TOTAL_W      = 32;

  // Command queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### sv/fla_front.sv
// Front end of the allocator: accepts requests and classifies them into commands.
// Depends on fla_pkg.
module fla_front (
  input  logic                                 in_valid,
  input  logic                                 action,
  input  logic [fla_pkg::SLOT_PORT_W-1:0]      free_slot,
  input  logic                                 free_is_null,
  input  logic                                 init_busy,
  input  fla_pkg::q_stat_t                     q_stat,
  output logic                                 in_stall,
  output logic                                 push,
  output fla_pkg::op_t                         op,
  output logic [fla_pkg::IDX_W-1:0]            slot
);

  // A return of a null slot or of a slot beyond the pool is turned into a no-op.
  always_comb begin
    if (action == fla_pkg::ACT_ALLOC) begin
      op = fla_pkg::OP_ALLOC;
    end else if (free_is_null || (int'(free_slot) >= fla_pkg::SLOT_COUNT)) begin
      op = fla_pkg::OP_NULL;
    end else begin
      op = fla_pkg::OP_FREE;
    end
  end

  assign slot     = fla_pkg::IDX_W'(free_slot);
  assign in_stall = init_busy | q_stat.full;
  assign push     = in_valid & ~in_stall;

endmodule

### sv/fla_queue.sv
// Small command queue between the allocator front end and back end.
// Depends on fla_pkg for the status struct.
module fla_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 2,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              pop,
  output logic [DATA_W-1:0] rd_data,
  output fla_pkg::q_stat_t  q_stat
);

  logic [DATA_W-1:0] entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign q_stat.full  = (count == CNT_W'(DEPTH));
  assign q_stat.empty = (count == '0);
  assign rd_data      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### sv/fla_back.sv
// Back end of the allocator: link memory, list head, counters and result register.
// Depends on fla_pkg.
module fla_back (
  input  logic                                clk,
  input  logic                                rst,
  input  fla_pkg::q_stat_t                    q_stat,
  input  fla_pkg::op_t                        q_op,
  input  logic [fla_pkg::IDX_W-1:0]           q_slot,
  output logic                                pop,
  output logic                                init_busy,
  output logic                                out_valid,
  input  logic                                out_stall,
  output fla_pkg::status_t                    status,
  output logic [fla_pkg::SLOT_PORT_W-1:0]     granted_slot,
  output logic [fla_pkg::COUNT_PORT_W-1:0]    in_use_count,
  output logic [fla_pkg::TOTAL_W-1:0]         lifetime_allocs,
  output logic [fla_pkg::TOTAL_W-1:0]         lifetime_frees
);

  localparam int SLOT_COUNT = fla_pkg::SLOT_COUNT;
  localparam int IDX_W      = fla_pkg::IDX_W;
  localparam int LINK_W     = fla_pkg::LINK_W;

  localparam logic [1:0] S_INIT = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;

  logic [1:0]                 state, state_next;
  logic [IDX_W-1:0]           init_idx;
  logic [LINK_W-1:0]          head, head_next;
  logic [LINK_W-1:0]          used, used_next;
  logic [fla_pkg::TOTAL_W-1:0] alloc_total, alloc_total_next;
  logic [fla_pkg::TOTAL_W-1:0] free_total, free_total_next;
  logic [IDX_W-1:0]           pend_slot;
  logic                       pend_load;
  logic [IDX_W-1:0]           out_grant, out_grant_next;
  fla_pkg::status_t           out_status, out_status_next;
  logic                       out_valid_next;
  logic                       out_load;

  // Link memory: one write port and one registered read port.
  logic [LINK_W-1:0] links [SLOT_COUNT];
  logic              wr_en, rd_en;
  logic [IDX_W-1:0]  wr_addr, rd_addr;
  logic [LINK_W-1:0] wr_data, rd_data;

  logic out_free;
  logic list_empty;

  assign out_free   = !out_valid || !out_stall;
  assign list_empty = (head >= LINK_W'(SLOT_COUNT));
  assign init_busy  = (state == S_INIT);

  always_comb begin
    state_next       = state;
    head_next        = head;
    used_next        = used;
    alloc_total_next = alloc_total;
    free_total_next  = free_total;
    out_grant_next   = out_grant;
    out_status_next  = out_status;
    out_load         = 1'b0;
    pend_load        = 1'b0;
    pop              = 1'b0;
    wr_en            = 1'b0;
    wr_addr          = init_idx;
    wr_data          = LINK_W'(init_idx) + LINK_W'(1);
    rd_en            = 1'b0;
    rd_addr          = IDX_W'(head);
    unique case (state)
      S_INIT: begin
        wr_en = 1'b1;
        if (init_idx == IDX_W'(SLOT_COUNT - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!q_stat.empty) begin
          unique case (q_op)
            fla_pkg::OP_ALLOC: begin
              if (list_empty) begin
                if (out_free) begin
                  pop             = 1'b1;
                  out_load        = 1'b1;
                  out_status_next = fla_pkg::STAT_EXHAUSTED;
                  out_grant_next  = '0;
                end
              end else begin
                // Start the link read; the result is finished in S_WAIT once the output is free.
                pop        = 1'b1;
                rd_en      = 1'b1;
                pend_load  = 1'b1;
                state_next = S_WAIT;
              end
            end
            fla_pkg::OP_FREE: begin
              if (out_free) begin
                pop             = 1'b1;
                wr_en           = 1'b1;
                wr_addr         = q_slot;
                wr_data         = head;
                head_next       = LINK_W'(q_slot);
                used_next       = (used != '0) ? used - 1'b1 : used;
                free_total_next = (free_total != '1) ? free_total + 1'b1 : free_total;
                out_load        = 1'b1;
                out_status_next = fla_pkg::STAT_FREED;
                out_grant_next  = '0;
              end
            end
            default: begin
              if (out_free) begin
                pop             = 1'b1;
                out_load        = 1'b1;
                out_status_next = fla_pkg::STAT_NULL_FREE;
                out_grant_next  = '0;
              end
            end
          endcase
        end
      end
      S_WAIT: begin
        if (out_free) begin
          head_next        = rd_data;
          used_next        = (used < LINK_W'(SLOT_COUNT)) ? used + 1'b1 : used;
          alloc_total_next = (alloc_total != '1) ? alloc_total + 1'b1 : alloc_total;
          out_load         = 1'b1;
          out_status_next  = fla_pkg::STAT_ALLOCATED;
          out_grant_next   = pend_slot;
          state_next       = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    out_valid_next = out_load | (out_valid & out_stall);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      links[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= links[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (pend_load) begin
      pend_slot <= IDX_W'(head);
    end
    if (out_load) begin
      out_grant  <= out_grant_next;
      out_status <= out_status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_INIT;
      init_idx    <= '0;
      head        <= '0;
      used        <= '0;
      alloc_total <= '0;
      free_total  <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      head        <= head_next;
      used        <= used_next;
      alloc_total <= alloc_total_next;
      free_total  <= free_total_next;
      out_valid   <= out_valid_next;
      if (state == S_INIT) begin
        init_idx <= init_idx + 1'b1;
      end
    end
  end

  // Counters change only when a result is loaded, so they can be shown directly.
  assign status          = out_status;
  assign granted_slot    = fla_pkg::SLOT_PORT_W'(out_grant);
  assign in_use_count    = fla_pkg::COUNT_PORT_W'(used);
  assign lifetime_allocs = alloc_total;
  assign lifetime_frees  = free_total;

endmodule

### sv/free_list_slot_allocator_core.sv
// Top level of the free-list slot allocator: front end, command queue, back end.
// Depends on fla_pkg, fla_front, fla_queue and fla_back.
//
// Usage: requests arrive on the input channel (in_valid / in_stall) with fields
// action, free_slot and free_is_null. Every request produces exactly one result
// on the output channel (out_valid / out_stall) carrying status, granted_slot,
// in_use_count, lifetime_allocs and lifetime_frees. A request is taken at a
// rising edge with valid high and stall low on its channel.
// The front end classifies a request (allocate, return, or ignored return) and
// places it in a two-entry queue. The back end executes one command at a time
// against the link memory. A return, an ignored request or an allocation from
// an empty pool is finished by the back end in S_IDLE; an allocation that finds
// a free slot goes on through S_WAIT, since the head's link comes from the
// memory's registered read port. Returns sustain one request per cycle while
// the receiver does not stall; during an allocation the back end waits in
// S_WAIT and takes no new command. After reset the back end sweeps the link
// memory once, writing slot i -> i + 1; in_stall stays high during that sweep.
// When the receiver stalls, the result register holds and no new result is
// loaded; the queue keeps taking requests until it fills, then in_stall rises.
module free_list_slot_allocator_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                action,
  input  logic [fla_pkg::SLOT_PORT_W-1:0]     free_slot,
  input  logic                                free_is_null,
  output logic                                out_valid,
  input  logic                                out_stall,
  output fla_pkg::status_t                    status,
  output logic [fla_pkg::SLOT_PORT_W-1:0]     granted_slot,
  output logic [fla_pkg::COUNT_PORT_W-1:0]    in_use_count,
  output logic [fla_pkg::TOTAL_W-1:0]         lifetime_allocs,
  output logic [fla_pkg::TOTAL_W-1:0]         lifetime_frees
);

  localparam int IDX_W   = fla_pkg::IDX_W;
  localparam int CMD_W   = fla_pkg::OP_W + IDX_W;
  localparam int Q_DEPTH = 2;

  logic             push;
  logic             pop;
  logic             init_busy;
  fla_pkg::q_stat_t q_stat;
  fla_pkg::op_t     front_op;
  logic [IDX_W-1:0] front_slot;
  logic [CMD_W-1:0] q_rd_data;
  fla_pkg::op_t     q_op;
  logic [IDX_W-1:0] q_slot;

  fla_front u_front (
    .in_valid     (in_valid),
    .action       (action),
    .free_slot    (free_slot),
    .free_is_null (free_is_null),
    .init_busy    (init_busy),
    .q_stat       (q_stat),
    .in_stall     (in_stall),
    .push         (push),
    .op           (front_op),
    .slot         (front_slot)
  );

  fla_queue #(.DATA_W(CMD_W), .DEPTH(Q_DEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data ({front_op, front_slot}),
    .pop     (pop),
    .rd_data (q_rd_data),
    .q_stat  (q_stat)
  );

  assign q_op   = q_rd_data[CMD_W-1:IDX_W];
  assign q_slot = q_rd_data[IDX_W-1:0];

  fla_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_stat          (q_stat),
    .q_op            (q_op),
    .q_slot          (q_slot),
    .pop             (pop),
    .init_busy       (init_busy),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .granted_slot    (granted_slot),
    .in_use_count    (in_use_count),
    .lifetime_allocs (lifetime_allocs),
    .lifetime_frees  (lifetime_frees)
  );

  // No request may be taken while the link memory is still being initialized.
  a_no_accept_in_init: assert property (@(posedge clk) disable iff (rst)
    init_busy |-> !push)
    else $error("request taken during link memory initialization");

  // A stalled result must keep its counters, since they come straight from state.
  a_stalled_counters_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(lifetime_allocs) && $stable(lifetime_frees)
                                  && $stable(in_use_count)))
    else $error("counters changed while result was stalled");

  // The back end only takes commands that are present in the queue.
  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("command popped from empty queue");

  // A new allocation result with a changed granted slot never reports zero lifetime allocations.
  a_alloc_counts: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) ##1 (out_valid && status == fla_pkg::STAT_ALLOCATED
                                   && $changed(granted_slot)) |->
    (lifetime_allocs != '0))
    else $error("allocation reported with zero lifetime allocations");

endmodule

### tb/fla_result_checker.sv
// Result checker for the free-list slot allocator: predicts each result and compares.
// Depends on fla_pkg; instantiated by free_list_slot_allocator_core_test.
module fla_result_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic                              action,
  input  logic [fla_pkg::SLOT_PORT_W-1:0]   free_slot,
  input  logic                              free_is_null,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  fla_pkg::status_t                  status,
  input  logic [fla_pkg::SLOT_PORT_W-1:0]   granted_slot,
  input  logic [fla_pkg::COUNT_PORT_W-1:0]  in_use_count,
  input  logic [fla_pkg::TOTAL_W-1:0]       lifetime_allocs,
  input  logic [fla_pkg::TOTAL_W-1:0]       lifetime_frees,
  output int                                fail_count,
  output int                                pending
);

  localparam int SLOT_COUNT = fla_pkg::SLOT_COUNT;
  localparam int IDX_W      = fla_pkg::IDX_W;
  localparam int LINK_W     = fla_pkg::LINK_W;

  typedef struct packed {
    fla_pkg::status_t                  status;
    logic [fla_pkg::SLOT_PORT_W-1:0]   slot;
    logic [fla_pkg::COUNT_PORT_W-1:0]  in_use;
    logic [fla_pkg::TOTAL_W-1:0]       allocs;
    logic [fla_pkg::TOTAL_W-1:0]       frees;
  } outcome_t;

  // Shadow copy of the free list and the counters.
  logic [LINK_W-1:0]                next_link [SLOT_COUNT];
  logic [LINK_W-1:0]                head;
  logic [fla_pkg::COUNT_PORT_W-1:0] used;
  logic [fla_pkg::TOTAL_W-1:0]      alloc_total;
  logic [fla_pkg::TOTAL_W-1:0]      free_total;
  outcome_t                         expected_q [$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic void clear_pool();
    for (int i = 0; i < SLOT_COUNT; i++) next_link[i] = LINK_W'(i + 1);
    head = '0;
    used = '0;
    alloc_total = '0;
    free_total = '0;
  endfunction

  // Applies one request to the shadow list and returns the result it must produce.
  function automatic outcome_t apply_request(logic act, logic [fla_pkg::SLOT_PORT_W-1:0] slot,
                                             logic nul);
    outcome_t r;
    r = '0;
    if (act == fla_pkg::ACT_ALLOC) begin
      if (head >= SLOT_COUNT) begin
        r.status = fla_pkg::STAT_EXHAUSTED;
      end else begin
        r.status = fla_pkg::STAT_ALLOCATED;
        r.slot = head[fla_pkg::SLOT_PORT_W-1:0];
        head = next_link[head[IDX_W-1:0]];
        if (used < SLOT_COUNT) used = used + 1'b1;
        if (alloc_total != '1) alloc_total = alloc_total + 1'b1;
      end
    end else if (nul || slot >= SLOT_COUNT) begin
      r.status = fla_pkg::STAT_NULL_FREE;
    end else begin
      r.status = fla_pkg::STAT_FREED;
      next_link[slot[IDX_W-1:0]] = head;
      head = LINK_W'(slot);
      if (used != 0) used = used - 1'b1;
      if (free_total != '1) free_total = free_total + 1'b1;
    end
    r.in_use = used;
    r.allocs = alloc_total;
    r.frees = free_total;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp, logic [31:0] got);
    if (exp !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    outcome_t e;
    if (rst) begin
      clear_pool();
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with no request outstanding, status %0d slot %0d",
                   $time, status, granted_slot);
          fail_count++;
        end else begin
          e = expected_q.pop_front();
          check_field("status", 32'(e.status), 32'(status));
          check_field("granted_slot", 32'(e.slot), 32'(granted_slot));
          check_field("in_use_count", 32'(e.in_use), 32'(in_use_count));
          check_field("lifetime_allocs", e.allocs, lifetime_allocs);
          check_field("lifetime_frees", e.frees, lifetime_frees);
        end
      end
      if (in_valid && !in_stall) expected_q.push_back(apply_request(action, free_slot, free_is_null));
    end
    pending = expected_q.size();
  end

endmodule

### tb/free_list_slot_allocator_core_test.sv
// Testbench top for the free-list slot allocator: clock, reset, request stimulus, verdict.
// Depends on fla_pkg, free_list_slot_allocator_core and fla_result_checker.
module free_list_slot_allocator_core_test;

  localparam int ITEM_TARGET = 1050;
  // Cycles with no request or result accepted before the run is declared hung.
  // The worst honest quiet stretch is the post-reset link sweep or a long
  // receiver stall while the queue is full, so this is generous.
  localparam int IDLE_LIMIT  = 2000;

  // Request mix of a random phase: drain pulls the pool toward exhaustion,
  // refill hands slots back, balanced keeps the list churning.
  typedef enum logic [1:0] {MIX_BALANCED, MIX_DRAIN, MIX_REFILL} mix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic                              action = fla_pkg::ACT_ALLOC;
  logic [fla_pkg::SLOT_PORT_W-1:0]   free_slot = '0;
  logic                              free_is_null = 1'b0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  fla_pkg::status_t                  status;
  logic [fla_pkg::SLOT_PORT_W-1:0]   granted_slot;
  logic [fla_pkg::COUNT_PORT_W-1:0]  in_use_count;
  logic [fla_pkg::TOTAL_W-1:0]       lifetime_allocs;
  logic [fla_pkg::TOTAL_W-1:0]       lifetime_frees;

  int fail_count;
  int pending;

  // Non-null requests accepted so far; null returns do not count toward the target.
  int sent = 0;
  // Gap style of the current phase: 0 none, 1 short, 2 mostly short with a few long.
  int gap_mode = 0;
  mix_t mix = MIX_BALANCED;
  // Slots that came back granted and have not been returned yet by the stimulus.
  logic [fla_pkg::SLOT_PORT_W-1:0] held_slots [$];

  free_list_slot_allocator_core i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .free_slot      (free_slot),
    .free_is_null   (free_is_null),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .granted_slot   (granted_slot),
    .in_use_count   (in_use_count),
    .lifetime_allocs(lifetime_allocs),
    .lifetime_frees (lifetime_frees)
  );

  fla_result_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .free_slot      (free_slot),
    .free_is_null   (free_is_null),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .granted_slot   (granted_slot),
    .in_use_count   (in_use_count),
    .lifetime_allocs(lifetime_allocs),
    .lifetime_frees (lifetime_frees),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // The receiver alternates between stall-free stretches, short stalls and the
  // occasional long stall, so stalls land on both the return path and the
  // allocate path (through S_WAIT) of the back end.
  always @(posedge clk) begin : receiver_stall
    int stall_left;
    int pick;
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
    end else begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        out_stall <= 1'b0;
        stall_left = $urandom_range(0, 20);
      end else if (pick < 9) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(10, 40);
      end
    end
  end

  // Granted slots are remembered so that most returns hand back a slot that
  // is really in use; the rest are double or stray frees and null returns.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall && status == fla_pkg::STAT_ALLOCATED) begin
      held_slots.push_back(granted_slot);
    end
  end

  // Hang detection: any accepted request or result restarts the count.
  always @(posedge clk) begin : watchdog
    int idle_cycles;
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("free_list_slot_allocator_core_test: FAIL");
      $finish;
    end
  end

  // Presents one request and holds it until the allocator takes it, then
  // leaves a gap whose length follows the gap style of the current phase.
  task automatic send_request(logic act, logic [fla_pkg::SLOT_PORT_W-1:0] slot, logic nul);
    int gap;
    int pick;
    in_valid <= 1'b1;
    action <= act;
    free_slot <= slot;
    free_is_null <= nul;
    do @(posedge clk); while (in_stall);
    if (!(act == fla_pkg::ACT_FREE && nul)) sent++;
    pick = $urandom_range(0, 9);
    case (gap_mode)
      0: gap = 0;
      1: gap = (pick < 6) ? 0 : $urandom_range(1, 2);
      default: begin
        gap = (pick < 8) ? $urandom_range(0, 3) : $urandom_range(10, 40);
      end
    endcase
    if (gap != 0) begin
      in_valid <= 1'b0;
      free_slot <= 6'($urandom);
      free_is_null <= 1'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  // Picks one random request according to the current mix. Returns mostly
  // give back a held slot; the remainder are stray frees (never handed out or
  // already free, so the list gains duplicates) and null returns.
  task automatic send_random_request();
    int alloc_pct;
    int pick;
    int idx;
    logic act;
    case (mix)
      MIX_DRAIN:  alloc_pct = 85;
      MIX_REFILL: alloc_pct = 20;
      default:    alloc_pct = 50;
    endcase
    act = ($urandom_range(0, 99) < alloc_pct) ? fla_pkg::ACT_ALLOC : fla_pkg::ACT_FREE;
    if (act == fla_pkg::ACT_FREE && held_slots.size() == 0 && $urandom_range(0, 9) < 7) begin
      act = fla_pkg::ACT_ALLOC;
    end
    if (act == fla_pkg::ACT_ALLOC) begin
      // The slot and null fields are don't-cares on an allocate.
      send_request(fla_pkg::ACT_ALLOC, 6'($urandom), 1'($urandom));
    end else begin
      pick = $urandom_range(0, 99);
      if (held_slots.size() != 0 && pick < 88) begin
        idx = $urandom_range(0, held_slots.size() - 1);
        send_request(fla_pkg::ACT_FREE, held_slots[idx], 1'b0);
        held_slots.delete(idx);
      end else if (pick < 94) begin
        send_request(fla_pkg::ACT_FREE, 6'($urandom), 1'b0);
      end else begin
        send_request(fla_pkg::ACT_FREE, 6'($urandom), 1'b1);
      end
    end
  endtask

  initial begin
    int phase_len;
    int phases;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed opening, back to back. The first returns arrive with nothing
    // allocated, so the in-use count must stay pinned at zero while the list
    // grows; the slot and null fields take their extremes on allocates too.
    gap_mode = 0;
    send_request(fla_pkg::ACT_FREE, 6'd5, 1'b0);
    send_request(fla_pkg::ACT_ALLOC, 6'd63, 1'b1);
    send_request(fla_pkg::ACT_ALLOC, 6'd0, 1'b0);
    send_request(fla_pkg::ACT_ALLOC, 6'd63, 1'b0);
    send_request(fla_pkg::ACT_FREE, 6'd0, 1'b0);
    send_request(fla_pkg::ACT_FREE, 6'd63, 1'b0);
    // Null returns at both slot extremes leave everything untouched.
    send_request(fla_pkg::ACT_FREE, 6'd63, 1'b1);
    send_request(fla_pkg::ACT_FREE, 6'd0, 1'b1);
    send_request(fla_pkg::ACT_ALLOC, 6'd0, 1'b1);
    send_request(fla_pkg::ACT_ALLOC, 6'd0, 1'b0);
    // A double free makes the slot link to itself, so it is granted twice.
    send_request(fla_pkg::ACT_FREE, 6'd2, 1'b0);
    send_request(fla_pkg::ACT_FREE, 6'd2, 1'b0);
    send_request(fla_pkg::ACT_ALLOC, 6'd21, 1'b0);
    send_request(fla_pkg::ACT_ALLOC, 6'd42, 1'b1);
    // A return directly followed by an allocate reads back the link it just wrote.
    send_request(fla_pkg::ACT_FREE, 6'd42, 1'b0);
    send_request(fla_pkg::ACT_ALLOC, 6'd0, 1'b0);
    send_request(fla_pkg::ACT_FREE, 6'd0, 1'b0);
    send_request(fla_pkg::ACT_FREE, 6'd63, 1'b0);
    send_request(fla_pkg::ACT_FREE, 6'd1, 1'b0);
    send_request(fla_pkg::ACT_FREE, 6'd2, 1'b0);
    held_slots.delete();

    // Random phases. The first is a long drain. The directed returns above left
    // the free list in a loop, so allocations cannot run it dry, and the drain
    // pushes the in-use count toward its saturation point.
    phases = 0;
    while (sent < ITEM_TARGET) begin
      if (phases == 0) begin
        mix = MIX_DRAIN;
        phase_len = 110;
      end else begin
        mix = mix_t'($urandom_range(0, 2));
        phase_len = $urandom_range(40, 120);
      end
      gap_mode = $urandom_range(0, 2);
      repeat (phase_len) send_random_request();
      phases++;
      // Let the allocator run completely dry of work now and then; the
      // second phase boundary always does so.
      if (phases == 2 || $urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        // The checker records the last request at this same edge, so the
        // outstanding count is looked at from the next edge on.
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    // A few extra cycles catch any stray result that trails the last one.
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("free_list_slot_allocator_core_test: PASS");
    end else begin
      $display("free_list_slot_allocator_core_test: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
sv/fla_pkg.sv
sv/fla_front.sv
sv/fla_queue.sv
sv/fla_back.sv
sv/free_list_slot_allocator_core.sv
tb/fla_result_checker.sv
tb/free_list_slot_allocator_core_test.sv
